FILE: hdl/assert_macros.svh
// Assertion macros shared by the servo packet framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define SWPF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define SWPF_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: hdl/swpf_pkg.sv
// Types and constants of the servo write packet framer.
`default_nettype none

package swpf_pkg;

  // Command kind codes.
  localparam logic KindGoal   = 1'b0;
  localparam logic KindTorque = 1'b1;

  // Fixed packet bytes.
  localparam logic [7:0] SyncByte   = 8'hFF;
  localparam logic [7:0] InstrWrite = 8'h03;
  localparam logic [7:0] LenGoal    = 8'h07;
  localparam logic [7:0] LenTorque  = 8'h04;
  localparam logic [7:0] AddrGoal   = 8'h1E;
  localparam logic [7:0] AddrTorque = 8'h18;
  localparam logic [7:0] TorqueOff  = 8'h00;

  // Speed word for the non-genuine servo type; the genuine one gets zero.
  localparam logic [7:0] SpeedLoAlt = 8'hFF;
  localparam logic [7:0] SpeedHiAlt = 8'h03;

  // Byte positions within a packet.
  localparam int unsigned IdxW = 4;
  localparam logic [IdxW-1:0] IdxSync0   = 4'd0;
  localparam logic [IdxW-1:0] IdxSync1   = 4'd1;
  localparam logic [IdxW-1:0] IdxId      = 4'd2;
  localparam logic [IdxW-1:0] IdxLen     = 4'd3;
  localparam logic [IdxW-1:0] IdxInstr   = 4'd4;
  localparam logic [IdxW-1:0] IdxAddr    = 4'd5;
  localparam logic [IdxW-1:0] IdxParam1  = 4'd6;
  localparam logic [IdxW-1:0] IdxParam2  = 4'd7;
  localparam logic [IdxW-1:0] IdxParam3  = 4'd8;
  localparam logic [IdxW-1:0] IdxParam4  = 4'd9;
  localparam logic [IdxW-1:0] IdxLastGoal   = 4'd10;
  localparam logic [IdxW-1:0] IdxLastTorque = 4'd7;

  // Classified command passed from the front end to the serializer.
  typedef struct packed {
    logic       kind;
    logic [7:0] servo_id;
    logic [7:0] goal_lo;
    logic [1:0] goal_hi;
    logic       genuine;
    logic [7:0] checksum;
  } swpf_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/servo_write_packet_framer_unit.sv
// Top level of the servo write packet framer.
// The first byte of a packet passes through the front stage, the command queue and the output register.
// The serializer sends one byte per cycle while the receiver does not stall it; a goal packet
// has eleven bytes and a torque-off packet eight, and the queue gives up one command per packet.
// The front stage and the command queue hold further commands while a packet goes out.
// Reset clears the stage, queue and serializer control; no packet is in flight after it.
`default_nettype none

module servo_write_packet_framer_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] servo_id_i,
  input  wire logic [9:0] goal_position_i,
  input  wire logic       genuine_servo_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      tx_byte_o,
  output logic            last_byte_o
);
  import swpf_pkg::*;

  logic      front_valid;
  swpf_cmd_t front_cmd;
  logic      queue_full;
  logic      queue_valid;
  swpf_cmd_t queue_head;
  logic      queue_pop;

  // Command classification.
  swpf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .servo_id_i      (servo_id_i),
    .goal_position_i (goal_position_i),
    .genuine_servo_i (genuine_servo_i),
    .cmd_valid_o     (front_valid),
    .cmd_full_i      (queue_full),
    .cmd_o           (front_cmd)
  );

  // Decoupling queue.
  swpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_cmd),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .head_o      (queue_head)
  );

  // Packet serializer.
  swpf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_head),
    .cmd_pop_o   (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_byte_o   (tx_byte_o),
    .last_byte_o (last_byte_o)
  );

endmodule

`default_nettype wire

FILE: hdl/swpf_front.sv
// Front end: accepts commands, classifies them and precomputes the checksum.
`default_nettype none

module swpf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [7:0]         servo_id_i,
  input  wire logic [9:0]         goal_position_i,
  input  wire logic               genuine_servo_i,
  output logic                    cmd_valid_o,
  input  wire logic               cmd_full_i,
  output swpf_pkg::swpf_cmd_t     cmd_o
);
  import swpf_pkg::*;

  logic       valid_q, valid_d;
  swpf_cmd_t  cmd_q, cmd_d;
  logic       accept;
  logic       advance;
  logic [7:0] param_sum;

  // The stage empties into the queue whenever the queue has room.
  assign advance    = !valid_q || !cmd_full_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // Sum of the variable parameter bytes plus the fixed header bytes.
  always_comb begin
    param_sum = '0;
    if (kind_i == KindGoal) begin
      param_sum = LenGoal + InstrWrite + AddrGoal + goal_position_i[7:0]
                + {6'd0, goal_position_i[9:8]};
      if (!genuine_servo_i) begin
        param_sum = param_sum + SpeedLoAlt + SpeedHiAlt;
      end
    end else begin
      param_sum = LenTorque + InstrWrite + AddrTorque + TorqueOff;
    end
  end

  // Build the command descriptor.
  always_comb begin
    cmd_d.kind     = kind_i;
    cmd_d.servo_id = servo_id_i;
    cmd_d.goal_lo  = goal_position_i[7:0];
    cmd_d.goal_hi  = goal_position_i[9:8];
    cmd_d.genuine  = genuine_servo_i;
    cmd_d.checksum = ~(param_sum + servo_id_i);
    valid_d        = accept ? 1'b1 : (valid_q && cmd_full_i);
  end

  // Stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  `include "assert_macros.svh"

  `SWPF_ASSERT(a_front_hold, clk_i, rst_ni, (valid_q && cmd_full_i) |=> valid_q && $stable(cmd_q), "front command lost while queue full")

endmodule

`default_nettype wire

FILE: hdl/swpf_queue.sv
// Short command queue between the front end and the serializer.
`default_nettype none

module swpf_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire swpf_pkg::swpf_cmd_t push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output swpf_pkg::swpf_cmd_t     head_o
);
  import swpf_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  swpf_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == CntFull);
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `include "assert_macros.svh"

  `SWPF_ASSERT_NEVER(a_queue_over, clk_i, rst_ni, count_q > CntFull, "queue fill count beyond depth")
  `SWPF_ASSERT(a_queue_count, clk_i, rst_ni, (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1, "queue count did not follow a push")

endmodule

`default_nettype wire

FILE: hdl/swpf_back.sv
// Serializer: walks the head command and emits one packet byte per beat.
`default_nettype none

module swpf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cmd_valid_i,
  input  wire swpf_pkg::swpf_cmd_t cmd_i,
  output logic                    cmd_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              tx_byte_o,
  output logic                    last_byte_o
);
  import swpf_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      tx_byte_q, byte_d;
  logic            last_q, last_d;
  logic            out_free;
  logic            load;

  // The output register takes a new beat once its current one is gone.
  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = out_free && cmd_valid_i;

  // Byte selection by position in the packet.
  always_comb begin
    last_d = (cmd_i.kind == KindGoal) ? (idx_q == IdxLastGoal) : (idx_q == IdxLastTorque);
    case (idx_q)
      IdxSync0:  byte_d = SyncByte;
      IdxSync1:  byte_d = SyncByte;
      IdxId:     byte_d = cmd_i.servo_id;
      IdxLen:    byte_d = (cmd_i.kind == KindGoal) ? LenGoal : LenTorque;
      IdxInstr:  byte_d = InstrWrite;
      IdxAddr:   byte_d = (cmd_i.kind == KindGoal) ? AddrGoal : AddrTorque;
      IdxParam1: byte_d = (cmd_i.kind == KindGoal) ? cmd_i.goal_lo : TorqueOff;
      IdxParam2: byte_d = (cmd_i.kind == KindGoal) ? {6'd0, cmd_i.goal_hi} : cmd_i.checksum;
      IdxParam3: byte_d = cmd_i.genuine ? 8'h00 : SpeedLoAlt;
      IdxParam4: byte_d = cmd_i.genuine ? 8'h00 : SpeedHiAlt;
      default:   byte_d = cmd_i.checksum;
    endcase
  end

  // Position counter and output valid.
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = cmd_valid_i;
    end
    if (load) begin
      idx_d = last_d ? '0 : idx_q + 1'b1;
    end
  end

  assign cmd_pop_o = load && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_byte_q <= byte_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_byte_o   = tx_byte_q;
  assign last_byte_o = last_q;

  `include "assert_macros.svh"

  `SWPF_ASSERT(a_back_wrap, clk_i, rst_ni, (load && last_d) |=> idx_q == '0, "byte position did not restart after checksum")
  `SWPF_ASSERT_NEVER(a_back_range, clk_i, rst_ni, idx_q > IdxLastGoal, "byte position beyond longest packet")

endmodule

`default_nettype wire

FILE: bench/servo_write_packet_framer_unit_test.sv
// Self-checking testbench for the servo write packet framer: commands in, packet bytes out.
`timescale 1ns / 1ps

module servo_write_packet_framer_unit_test;
  import swpf_pkg::*;

  // One byte of a packet as it should leave the framer.
  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } packet_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       kind_i;
  logic [7:0] servo_id_i;
  logic [9:0] goal_position_i;
  logic       genuine_servo_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] tx_byte_o;
  logic       last_byte_o;

  packet_byte_t pending_bytes[$];
  int failures = 0;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;

  servo_write_packet_framer_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .servo_id_i      (servo_id_i),
    .goal_position_i (goal_position_i),
    .genuine_servo_i (genuine_servo_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tx_byte_o       (tx_byte_o),
    .last_byte_o     (last_byte_o)
  );

  // Free-running 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Append the bytes of one write packet to the queue of expected bytes.
  function automatic void frame_write_packet(input logic kind, input logic [7:0] id,
                                             input logic [9:0] goal, input logic genuine);
    logic [7:0] params [5];
    logic [7:0] len;
    logic [7:0] sum;
    int n_params;
    if (kind == KindGoal) begin
      len = LenGoal;
      params[0] = AddrGoal;
      params[1] = goal[7:0];
      params[2] = {6'b0, goal[9:8]};
      params[3] = genuine ? 8'h00 : SpeedLoAlt;
      params[4] = genuine ? 8'h00 : SpeedHiAlt;
      n_params = 5;
    end else begin
      len = LenTorque;
      params[0] = AddrTorque;
      params[1] = TorqueOff;
      n_params = 2;
    end
    pending_bytes.push_back('{SyncByte, 1'b0});
    pending_bytes.push_back('{SyncByte, 1'b0});
    pending_bytes.push_back('{id, 1'b0});
    pending_bytes.push_back('{len, 1'b0});
    pending_bytes.push_back('{InstrWrite, 1'b0});
    // The sum wraps at eight bits before it is inverted.
    sum = id + len + InstrWrite;
    for (int i = 0; i < n_params; i++) begin
      pending_bytes.push_back('{params[i], 1'b0});
      sum = sum + params[i];
    end
    pending_bytes.push_back('{~sum, 1'b1});
  endfunction

  // Present one command, with random idle cycles ahead of it, and wait until it is taken.
  task automatic send_command(input logic kind, input logic [7:0] id,
                              input logic [9:0] goal, input logic genuine);
    bit placed;
    placed = 1'b0;
    while (!placed) begin
      @(negedge clk_i);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i      <= 1'b1;
        kind_i          <= kind;
        servo_id_i      <= id;
        goal_position_i <= goal;
        genuine_servo_i <= genuine;
        placed = 1'b1;
      end
    end
    do @(posedge clk_i); while (in_stall_o);
    frame_write_packet(kind, id, goal, genuine);
  endtask

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  // Compare every accepted output beat with the oldest expected byte.
  always @(posedge clk_i) begin
    packet_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte %02h with last_byte %0b", tx_byte_o, last_byte_o);
        failures++;
      end else begin
        want = pending_bytes.pop_front();
        if (tx_byte_o !== want.tx) begin
          $error("tx_byte: expected %02h, actual %02h", want.tx, tx_byte_o);
          failures++;
        end
        if (last_byte_o !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, last_byte_o);
          failures++;
        end
      end
    end
  end

  // Goal packets at the corners of the id and position ranges, both servo types.
  task automatic test_goal_packets();
    send_command(KindGoal, 8'h00, 10'h000, 1'b1);
    send_command(KindGoal, 8'hFF, 10'h3FF, 1'b0);
    send_command(KindGoal, 8'hAA, 10'h155, 1'b0);
    send_command(KindGoal, 8'h55, 10'h2AA, 1'b1);
    send_command(KindGoal, 8'h01, 10'h100, 1'b1);
    send_command(KindGoal, 8'hFE, 10'h0FF, 1'b0);
  endtask

  // Torque-off packets must not depend on the position or servo type fields.
  task automatic test_torque_packets();
    send_command(KindTorque, 8'h00, 10'h000, 1'b0);
    send_command(KindTorque, 8'hFF, 10'h3FF, 1'b1);
    send_command(KindTorque, 8'h3C, 10'h2AA, 1'b0);
    send_command(KindTorque, 8'h3C, 10'h155, 1'b1);
  endtask

  // Sums that wrap, and sums that make the checksum all zeros or all ones.
  task automatic test_checksum_wrap();
    send_command(KindGoal, 8'hFF, 10'h3FF, 1'b0);
    send_command(KindGoal, 8'hD8, 10'h000, 1'b1);
    send_command(KindGoal, 8'hD7, 10'h000, 1'b1);
    send_command(KindTorque, 8'hE0, 10'h000, 1'b0);
    send_command(KindTorque, 8'hE1, 10'h3FF, 1'b1);
  endtask

  // Random commands under the given sender idling and receiver stalling.
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    logic [7:0] id;
    logic [9:0] goal;
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      // Lean on the range ends now and then.
      id = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
      goal = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 10'h3FF : 10'h000)
                                      : 10'($urandom);
      send_command(1'($urandom), id, goal, 1'($urandom));
    end
  endtask

  // Stimulus sequence.
  initial begin
    int waited;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    kind_i          = KindGoal;
    servo_id_i      = 8'h00;
    goal_position_i = 10'h000;
    genuine_servo_i = 1'b0;
    out_stall_i     = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_goal_packets();
    test_torque_packets();
    test_checksum_wrap();
    test_random_traffic(120, 0, 0);
    test_random_traffic(120, 55, 0);
    test_random_traffic(120, 0, 55);
    test_random_traffic(120, 27, 27);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_bytes.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_bytes.size() != 0) begin
      $error("%0d packet bytes never arrived", pending_bytes.size());
      failures++;
    end
    repeat (20) @(posedge clk_i);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog in case the framer hangs.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
